// ----- rtl/core/text_console_char_writer_assert.svh -----
// Assertion macros for the checker file.
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    localparam int LINE_BYTES   = 160;
    localparam int SCREEN_ROWS  = 25;
    localparam int BUFFER_BYTES = 32768;

    localparam int WINDOW_BYTES = LINE_BYTES * SCREEN_ROWS;
    localparam int MAX_LINE     = (BUFFER_BYTES - 1) / LINE_BYTES;

    // Offset register and the sum of one step (offset plus at most one line).
    localparam int OFF_W  = $clog2(BUFFER_BYTES);
    localparam int SUM_W  = $clog2(BUFFER_BYTES + LINE_BYTES);
    localparam int LINE_W = $clog2(MAX_LINE + 3);
    localparam int COL_W  = $clog2(LINE_BYTES);
    localparam int CSUM_W = $clog2(LINE_BYTES + 2);

    localparam int TOP_MAX = ((MAX_LINE + 2) * LINE_BYTES > WINDOW_BYTES) ?
                             (MAX_LINE + 2) * LINE_BYTES : WINDOW_BYTES;
    localparam int TOP_W   = $clog2(TOP_MAX + 1);

    // Fixed field widths.
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 15;
    localparam int CELL_W = 14;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam logic [CHAR_W-1:0] CODE_LF = 8'h0a;
    localparam logic [CHAR_W-1:0] CODE_CR = 8'h0d;
    localparam logic [CHAR_W-1:0] CODE_BS = 8'h08;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } pos_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [CHAR_W-1:0] write_char;
        logic [CHAR_W-1:0] write_attr;
        logic              clear_screen;
        logic [CELL_W-1:0] start_address;
        logic [CELL_W-1:0] cursor_position;
    } result_t;

endpackage

// ----- rtl/core/text_console_char_writer.sv -----
// Text console character writer.
// The input stream carries one character word per transfer: s_tdata[7:0] is the
// character code and s_tdata[15:8] the color attribute. Line feed, carriage
// return and backspace move the cursor; every other code is written to the
// text buffer with its attribute and advances one cell.
// Each input word yields exactly one output word with the cell write, the
// display start address for scrolling and the new cursor position. When the
// offset runs past the end of the buffer it wraps to zero and the clear flag
// in m_tuser is raised; the receiver applies the cell write before the clear.
// m_tvalid rises in the cycle after input acceptance. The block takes one
// word per cycle: the step is a short piece of logic between the offset
// register and the output register, and s_tready stays high while the output
// register is empty or being drained in the same cycle.
// When the receiver stalls, the output word holds and s_tready drops, so at
// most one finished word waits. Synchronous reset clears the offset to the
// first cell and empties the output register.
module text_console_char_writer
    import tcw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: char_code[7:0], attribute[15:8]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: write_address[14:0], write_char[22:15], write_attr[30:23],
    //          start_address[44:31], cursor_position[58:45], zeros above
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: write_valid[0], clear_screen[1]
    output logic [M_TUSER_W-1:0] m_tuser
);

    pos_t    pos_reg;
    pos_t    pos_next;
    result_t res_reg;
    result_t res_next;
    logic    m_tvalid_reg;
    logic    m_tvalid_next;
    logic    s_accept;

    // The output register can take a new word whenever it is empty or the
    // waiting word leaves in this same cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    tcw_step u_step (
        .pos       (pos_reg),
        .char_code (s_tdata[CHAR_W-1:0]),
        .attribute (s_tdata[2*CHAR_W-1:CHAR_W]),
        .pos_next  (pos_next),
        .result    (res_next)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Cursor state advances only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                pos_reg <= pos_next;
            end
        end
    end

    // Payload needs no reset; it is qualified by m_tvalid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {res_reg.clear_screen, res_reg.write_valid};
    assign m_tdata  = {
        (M_TDATA_W - ADDR_W - 2*CHAR_W - 2*CELL_W)'(0),
        res_reg.cursor_position,
        res_reg.start_address,
        res_reg.write_attr,
        res_reg.write_char,
        res_reg.write_address
    };

endmodule

// ----- rtl/core/tcw_step.sv -----
module tcw_step
    import tcw_pkg::*;
(
    input  pos_t              pos,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CHAR_W-1:0] attribute,
    output pos_t              pos_next,
    output result_t           result
);

    logic [SUM_W-1:0]  new_off;
    logic [LINE_W-1:0] new_line;
    logic [COL_W-1:0]  new_col;
    logic [CSUM_W-1:0] col_sum;
    logic [LINE_W-1:0] lines_up;
    logic [TOP_W-1:0]  top;
    logic [TOP_W-1:0]  start_full;
    logic              overflow;

    // Line and column are kept beside the offset so no divider is needed.
    always_comb begin
        result   = '0;
        new_off  = SUM_W'(pos.off);
        new_line = pos.line;
        new_col  = pos.col;
        col_sum  = '0;
        case (char_code)
            CODE_LF: begin
                new_off  = SUM_W'(pos.off) - SUM_W'(pos.col) + SUM_W'(LINE_BYTES);
                new_line = pos.line + LINE_W'(1);
                new_col  = '0;
            end
            CODE_CR: begin
                new_off = SUM_W'(pos.off) - SUM_W'(pos.col);
                new_col = '0;
            end
            CODE_BS: begin
                if (pos.off <= OFF_W'(2)) begin
                    new_off  = '0;
                    new_line = '0;
                    new_col  = '0;
                end else begin
                    new_off = SUM_W'(pos.off) - SUM_W'(2);
                    if (pos.col >= COL_W'(2)) begin
                        new_col = pos.col - COL_W'(2);
                    end else begin
                        col_sum  = CSUM_W'(pos.col) + CSUM_W'(LINE_BYTES - 2);
                        new_col  = col_sum[COL_W-1:0];
                        new_line = pos.line - LINE_W'(1);
                    end
                end
                result.write_valid   = 1'b1;
                result.write_address = ADDR_W'(new_off);
            end
            default: begin
                result.write_valid   = 1'b1;
                result.write_address = ADDR_W'(pos.off);
                result.write_char    = char_code;
                result.write_attr    = attribute;
                new_off = SUM_W'(pos.off) + SUM_W'(2);
                col_sum = CSUM_W'(pos.col) + CSUM_W'(2);
                if (col_sum >= CSUM_W'(LINE_BYTES)) begin
                    col_sum  = col_sum - CSUM_W'(LINE_BYTES);
                    new_line = pos.line + LINE_W'(1);
                end
                new_col = col_sum[COL_W-1:0];
            end
        endcase

        overflow = (new_off >= SUM_W'(BUFFER_BYTES));

        // Bottom of the window sits one line past the rounded-up current line.
        lines_up   = new_line + LINE_W'(new_col != '0) + LINE_W'(1);
        top        = TOP_W'(lines_up) * TOP_W'(LINE_BYTES);
        start_full = top - TOP_W'(WINDOW_BYTES);

        if (overflow) begin
            pos_next               = '0;
            result.clear_screen    = 1'b1;
            result.start_address   = '0;
            result.cursor_position = '0;
        end else begin
            pos_next.off           = new_off[OFF_W-1:0];
            pos_next.line          = new_line;
            pos_next.col           = new_col;
            result.cursor_position = CELL_W'(new_off >> 1);
            if (top <= TOP_W'(WINDOW_BYTES)) begin
                result.start_address = '0;
            end else begin
                result.start_address = CELL_W'(start_full >> 1);
            end
        end
    end

endmodule

// ----- rtl/core/tcw_checker.sv -----
`include "text_console_char_writer_assert.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic              out_stall;
    logic              out_clear;
    logic              out_no_write;
    logic              out_print;
    logic [CELL_W-1:0] out_cursor;
    logic [CELL_W-1:0] out_cell;

    assign out_stall    = m_tvalid && !m_tready;
    assign out_clear    = m_tvalid && m_tuser[1];
    assign out_no_write = m_tvalid && !m_tuser[0];
    assign out_print    = m_tvalid && m_tuser[0] && !m_tuser[1] && (m_tdata[22:15] != 8'd0);
    assign out_cursor   = m_tdata[58:45];
    assign out_cell     = m_tdata[14:1];

    // A stalled output word holds until taken.
    `TCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable({m_tdata, m_tuser}))

    // With the output register empty the block must take input.
    `TCW_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // A wrap clears the screen and homes both the window and the cursor.
    `TCW_ASSERT_NOW(a_clear_homes, aclk, aresetn, out_clear, m_tdata[58:31] == 28'd0)

    // Without a cell write the write fields read as zero.
    `TCW_ASSERT_NOW(a_no_write_zero, aclk, aresetn, out_no_write, m_tdata[30:0] == 31'd0)

    // A nonzero character lands under the cursor, which then sits one cell on.
    `TCW_ASSERT_NOW(a_print_advance, aclk, aresetn, out_print, out_cursor == out_cell + 14'd1)

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (.*);

// ----- tb/sv/text_console_char_writer_tb.sv -----
`timescale 1ns / 100ps

// Stream testbench for the text console character writer.
// Every character word that the block accepts is run through a predictor
// that keeps its own copy of the byte offset and works out the one output
// word that the step must produce. Output words are checked in order, field
// by field, against that list of expected words.
module text_console_char_writer_tb;
    import tcw_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 4;
    // Cycles with no transfer on either side before the run is called hung.
    // The longest correct quiet stretch is the receiver hold-off below.
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1030;
    localparam int DRAIN_CYCLES = 8;
    // Byte offset of the first cell on the last line of the buffer.
    localparam int LAST_LINE_START = MAX_LINE * LINE_BYTES;

    // Predictor and in-order checker for the output words.
    class char_writer_scoreboard;
        int unsigned cur_offset;
        result_t     expected_words[$];
        int          mismatches;

        function new();
            cur_offset = 0;
            mismatches = 0;
        endfunction

        // Display start in cells: the line holding the offset (rounded up)
        // plus one more must sit at the bottom of the visible window.
        function int unsigned window_start(int unsigned off);
            int unsigned row;
            int unsigned top;
            row = off / LINE_BYTES;
            if (off % LINE_BYTES != 0) begin
                row++;
            end
            top = (row + 1) * LINE_BYTES;
            if (top <= WINDOW_BYTES) begin
                return 0;
            end
            return (top - WINDOW_BYTES) / 2;
        endfunction

        // One accepted character word: move the offset and queue the word
        // the block has to send for it.
        function void note_char(logic [CHAR_W-1:0] code, logic [CHAR_W-1:0] attr);
            result_t     want;
            int unsigned next;
            want = '0;
            next = cur_offset;
            if (code == CODE_LF) begin
                next = (cur_offset / LINE_BYTES) * LINE_BYTES + LINE_BYTES;
            end else if (code == CODE_CR) begin
                next = (cur_offset / LINE_BYTES) * LINE_BYTES;
            end else if (code == CODE_BS) begin
                // Backspace clamps at the first cell and blanks the cell.
                next = (cur_offset <= 2) ? 0 : cur_offset - 2;
                want.write_valid   = 1'b1;
                want.write_address = ADDR_W'(next);
            end else begin
                want.write_valid   = 1'b1;
                want.write_address = ADDR_W'(cur_offset);
                want.write_char    = code;
                want.write_attr    = attr;
                next = cur_offset + 2;
            end
            if (next < BUFFER_BYTES) begin
                want.start_address = CELL_W'(window_start(next));
            end else begin
                // Ran off the end: wrap to the top and ask for a clear.
                next = 0;
                want.clear_screen = 1'b1;
            end
            want.cursor_position = CELL_W'(next / 2);
            cur_offset = next;
            expected_words.push_back(want);
        endfunction

        // Four-state compare, so an unknown output bit counts as a mismatch.
        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(result_t got, logic [4:0] pad);
            result_t want;
            if (expected_words.size() == 0) begin
                $error("output word with nothing expected");
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("write_valid", want.write_valid, got.write_valid);
            compare_field("write_address", want.write_address, got.write_address);
            compare_field("write_char", want.write_char, got.write_char);
            compare_field("write_attr", want.write_attr, got.write_attr);
            compare_field("clear_screen", want.clear_screen, got.clear_screen);
            compare_field("start_address", want.start_address, got.start_address);
            compare_field("cursor_position", want.cursor_position, got.cursor_position);
            compare_field("tdata_pad", 0, pad);
        endfunction

        function int pending_count();
            return expected_words.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    char_writer_scoreboard sb = new();

    // Percent of cycles in which the sender or the receiver sits idle.
    int tx_idle_pct = 17;
    int rx_idle_pct = 58;
    // Raised by the main sequence to ask the receiver for a long hold-off.
    bit hold_req    = 1'b0;
    int items_sent  = 0;
    int quiet_cycles = 0;

    text_console_char_writer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, where the inputs set up
    // at the falling edge are stable and the block's registers still hold
    // their old values. The output is checked before the input is noted: a
    // word leaving the block always belongs to an earlier input.
    always @(posedge aclk) begin
        result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.write_valid     = m_tuser[0];
            seen.clear_screen    = m_tuser[1];
            seen.write_address   = m_tdata[14:0];
            seen.write_char      = m_tdata[22:15];
            seen.write_attr      = m_tdata[30:23];
            seen.start_address   = m_tdata[44:31];
            seen.cursor_position = m_tdata[58:45];
            sb.check_word(seen, m_tdata[63:59]);
        end
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_char(s_tdata[7:0], s_tdata[15:8]);
        end
    end

    // A run that stops moving words on both sides for too long has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_console_char_writer_tb: errors");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request that
    // this process times on its own while the sender keeps offering words.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offers one word, starting and ending at a falling edge. Valid is left
    // high on return, so back-to-back words keep it high without a glitch;
    // the next call or the caller lowers it when the sender goes idle.
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic [CHAR_W-1:0] attr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {attr, code};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic logic [CHAR_W-1:0] any_printable();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (c == CODE_LF || c == CODE_CR || c == CODE_BS) begin
            c = CHAR_W'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] any_attr();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // One random stretch of console traffic. The largest share looks like real
    // text (lines of characters with the odd backspace or return, ended by a
    // line feed); runs of line feeds push the offset deep into the buffer so
    // that scrolling and the wrap at the end get exercised; the rest is
    // noise over the whole byte range.
    task automatic send_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            n = $urandom_range(1, 50);
            repeat (n) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_char($urandom_range(0, 1) ? CODE_BS : CODE_CR, any_attr());
                end else begin
                    send_char(any_printable(), any_attr());
                end
            end
            send_char(CODE_LF, any_attr());
        end else if (kind < 72) begin
            repeat ($urandom_range(1, 30)) send_char(CODE_LF, any_attr());
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 20)) send_char(any_printable() ^ CHAR_W'(0), any_attr());
            repeat ($urandom_range(0, 4)) send_char(CHAR_W'($urandom_range(0, 255)), any_attr());
        end else if (sb.cur_offset >= BUFFER_BYTES / 2) begin
            // Walk down to the last line and fill it, so that a printable
            // character lands in the very last cell and wraps the offset.
            while (sb.cur_offset < LAST_LINE_START) begin
                send_char(CODE_LF, any_attr());
            end
            while (sb.cur_offset != 0) begin
                send_char(any_printable(), any_attr());
            end
        end else begin
            repeat ($urandom_range(20, 60)) send_char(CODE_LF, any_attr());
        end
    endtask

    // Lowers valid and waits until the block has handed over every word
    // that is still owed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending_count() != 0);
    endtask

    initial begin
        int phase;
        int target;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening: backspace and return at the very first cell, the
        // backspace clamp from the second cell, extreme and alternating bit
        // patterns in both bytes, the codes right beside the control codes,
        // and backspace stepping back over a line boundary.
        send_char(CODE_BS, 8'hff);
        send_char(CODE_CR, 8'h00);
        send_char(8'h00, 8'h00);
        send_char(CODE_BS, 8'h5a);
        send_char(8'hff, 8'hff);
        send_char(8'h55, 8'haa);
        send_char(8'haa, 8'h55);
        send_char(8'h07, 8'h01);
        send_char(8'h09, 8'h80);
        send_char(8'h0b, 8'h7f);
        send_char(8'h0c, 8'hfe);
        send_char(8'h0e, 8'h10);
        send_char(CODE_BS, 8'h33);
        send_char(CODE_CR, 8'hcc);
        send_char(CODE_LF, 8'hff);
        send_char(CODE_BS, 8'h00);
        send_char(CODE_LF, 8'h0f);
        send_char(CODE_LF, 8'hf0);
        send_char(8'h7f, 8'h80);
        send_char(CODE_CR, 8'h81);
        send_char(8'h80, 8'h7f);
        wait_drained();

        // Random traffic in three phases: a slow receiver, then a slow
        // sender, then no idling at all. The last phase opens with a long
        // receiver hold-off so the output register fills and input stalls.
        // Between phases the sender pauses until everything has come out.
        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 58 : 0;
            rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 17 : 0;
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target) begin
                send_burst();
            end
            wait_drained();
        end

        // Give a late or extra word time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("text_console_char_writer_tb: clean");
        end else begin
            $display("text_console_char_writer_tb: errors");
        end
        $finish;
    end

endmodule

// ----- text_console_char_writer.f -----
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_step.sv
rtl/core/text_console_char_writer.sv
rtl/core/tcw_checker.sv
tb/sv/text_console_char_writer_tb.sv
